[rtl/core/tfsd_pkg.sv]
package tfsd_pkg;

  // delay line geometry
  localparam int WIN_LEN = 36;
  localparam int PRE_LEN = 34;

  // reset magnitude of both slicer thresholds, in converter counts
  localparam int THRESH_RST_MAG = 205;

  typedef logic signed [1:0] trit_t;

  localparam trit_t TRIT_ZERO = 2'sb00;
  localparam trit_t TRIT_POS  = 2'sb01;
  localparam trit_t TRIT_NEG  = 2'sb11;

  // holds 0..WIN_LEN
  typedef logic [$clog2(WIN_LEN+1)-1:0] fill_t;

  typedef enum logic {
    REG_HIGH_THRESHOLD = 1'b0,
    REG_LOW_THRESHOLD  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0] code;
    logic       code_valid;
    logic       segment_end;
    logic       run_last;
  } result_t;

  // preamble repeats +1 -1 -1 +1
  function automatic trit_t pre_trit(input int i);
    logic [1:0] ph;
    ph = i[1:0];
    return (ph == 2'd0 || ph == 2'd3) ? TRIT_POS : TRIT_NEG;
  endfunction

  // oldest trit at index 0
  function automatic logic is_marker(input trit_t w [WIN_LEN]);
    logic pre_ok;
    logic tail_ok;
    pre_ok = 1'b1;
    for (int i = 0; i < PRE_LEN; i++) begin
      if (w[i] != pre_trit(i)) pre_ok = 1'b0;
    end
    tail_ok = (w[PRE_LEN] == TRIT_ZERO && w[PRE_LEN+1] == TRIT_POS) ||
              (w[PRE_LEN] == TRIT_POS  && w[PRE_LEN+1] == TRIT_NEG) ||
              (w[PRE_LEN] == TRIT_POS  && w[PRE_LEN+1] == TRIT_ZERO) ||
              (w[PRE_LEN] == TRIT_POS  && w[PRE_LEN+1] == TRIT_POS);
    return pre_ok & tail_ok;
  endfunction

  // returns {emit, code}; the pair (0,0) emits nothing
  function automatic logic [3:0] pair_code(input trit_t first, input trit_t second);
    logic [3:0] idx;
    logic [2:0] code;
    idx  = 4'(3 * (int'(first) + 1) + int'(second) + 1);
    code = (idx > 4'd4) ? 3'(idx - 4'd1) : idx[2:0];
    return {(idx != 4'd4), code};
  endfunction

endpackage

[rtl/core/ternary_frame_sync_decoder.sv]
// Ternary line decoder with sync-marker framing. Each input transfer carries one
// signed ADC sample taken at the symbol instant; it is sliced against the high and
// low threshold registers into a trit (+1 above high, else -1 below low, else 0)
// and shifted into a 36-trit delay line. Once the line is full its contents are
// compared in parallel with four sync markers (common 34-trit preamble of
// +1 -1 -1 +1 repeated, then +1 -1, and tails 0+1, +1-1, +1 0, +1+1). A match
// swallows the whole line and closes the current segment, giving a segment_end
// result if the segment held any data; otherwise the oldest trit leaves as data.
// Data trits pair up in order and each pair yields a 3-bit code, except (0,0)
// which yields nothing; an odd trit left when a segment closes is dropped.
// Rate: one sample is accepted every cycle unless a flush runs or the two-entry
// output queue is full; an ordinary sample gives at most one result, so the input
// keeps moving while one finished result waits on a stalled output. A sample with
// stream_end set starts a flush, which walks the delay line one trit per cycle,
// skipping stale entries, then draining the valid ones as data while holding
// whenever a result finds the queue full, and closes the final segment. No input
// is taken during the flush. Configuration writes are taken at any edge with
// cfg_we_i high and must only happen while the block is idle.
module ternary_frame_sync_decoder #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [0:0]                    cfg_index_i,
  input  logic [SAMPLE_BITS-1:0]        cfg_wdata_i,
  // sample channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          stream_end_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    code_o,
  output logic                          code_valid_o,
  output logic                          segment_end_o,
  output logic                          run_last_o
);

  localparam int WIN_LEN = tfsd_pkg::WIN_LEN;

  // reset thresholds, clamped to the sample range (same slicing result)
  localparam int SAMPLE_MAX = (1 << (SAMPLE_BITS - 1)) - 1;
  localparam int HIGH_RST_INT =
    (tfsd_pkg::THRESH_RST_MAG > SAMPLE_MAX) ? SAMPLE_MAX : tfsd_pkg::THRESH_RST_MAG;
  localparam int LOW_RST_INT =
    (tfsd_pkg::THRESH_RST_MAG > SAMPLE_MAX + 1) ? -(SAMPLE_MAX + 1)
                                                : -tfsd_pkg::THRESH_RST_MAG;
  localparam logic signed [SAMPLE_BITS-1:0] HIGH_RST = SAMPLE_BITS'(HIGH_RST_INT);
  localparam logic signed [SAMPLE_BITS-1:0] LOW_RST  = SAMPLE_BITS'(LOW_RST_INT);

  // threshold registers
  logic signed [SAMPLE_BITS-1:0] high_q;
  logic signed [SAMPLE_BITS-1:0] low_q;

  // delay line: index 0 is the next trit to leave, newest enters at the top
  tfsd_pkg::trit_t win_q [WIN_LEN];
  tfsd_pkg::trit_t win_d [WIN_LEN];
  tfsd_pkg::trit_t win_sh [WIN_LEN];
  tfsd_pkg::trit_t win_fl [WIN_LEN];

  // number of valid trits, counted from the top of the line
  tfsd_pkg::fill_t fill_q, fill_d;
  tfsd_pkg::fill_t fill_inc;
  tfsd_pkg::fill_t fill_step;

  // pairing and segment state
  tfsd_pkg::trit_t held_q, held_d;
  logic            phase_q, phase_d;
  logic            nonempty_q, nonempty_d;

  // flush engine: skip the stale entries, then drain the valid ones
  logic            flush_q, flush_d;
  tfsd_pkg::fill_t skip_q, skip_d;
  tfsd_pkg::fill_t left_q, left_d;

  // output queue
  tfsd_pkg::result_t fifo_q [2];
  logic              wr_ptr_q;
  logic              rd_ptr_q;
  logic [1:0]        cnt_q;
  logic              push;
  tfsd_pkg::result_t push_res;
  logic              pop;
  logic              room;

  logic            accept;
  tfsd_pkg::trit_t t_in;
  logic            full;
  logic            marker;
  tfsd_pkg::trit_t dt_trit;
  logic [3:0]      pc;
  logic            dt_emit;

  assign pop        = (cnt_q != 2'd0) & ~out_stall_i;
  assign room       = (cnt_q != 2'd2) | pop;
  assign in_stall_o = flush_q | ~room;
  assign accept     = in_valid_i & ~in_stall_o;

  // slicer, the +1 test wins when thresholds overlap
  always_comb begin
    if (sample_i > high_q) begin
      t_in = tfsd_pkg::TRIT_POS;
    end else if (sample_i < low_q) begin
      t_in = tfsd_pkg::TRIT_NEG;
    end else begin
      t_in = tfsd_pkg::TRIT_ZERO;
    end
  end

  // shifted views of the line
  always_comb begin
    for (int i = 0; i < WIN_LEN - 1; i++) begin
      win_sh[i] = win_q[i+1];
      win_fl[i] = win_q[i+1];
    end
    win_sh[WIN_LEN-1] = t_in;
    win_fl[WIN_LEN-1] = tfsd_pkg::TRIT_ZERO;
  end

  assign fill_inc = fill_q + tfsd_pkg::fill_t'(1);
  assign full     = (fill_inc == tfsd_pkg::fill_t'(WIN_LEN));
  assign marker   = full & tfsd_pkg::is_marker(win_sh);

  // one pairing unit shared by the sample path and the flush
  assign dt_trit = flush_q ? win_q[0] : win_sh[0];
  assign pc      = tfsd_pkg::pair_code(held_q, dt_trit);
  assign dt_emit = phase_q & pc[3];

  always_comb begin
    win_d      = win_q;
    fill_d     = fill_q;
    held_d     = held_q;
    phase_d    = phase_q;
    nonempty_d = nonempty_q;
    flush_d    = flush_q;
    skip_d     = skip_q;
    left_d     = left_q;
    fill_step  = fill_q;
    push       = 1'b0;
    push_res   = '0;

    if (accept) begin
      win_d = win_sh;
      if (marker) begin
        // marker swallows the line and closes the segment
        fill_step            = '0;
        push                 = nonempty_q;
        push_res.segment_end = 1'b1;
        nonempty_d           = 1'b0;
        phase_d              = 1'b0;
        held_d               = tfsd_pkg::TRIT_ZERO;
      end else if (full) begin
        // oldest trit leaves as data
        fill_step  = tfsd_pkg::fill_t'(WIN_LEN - 1);
        nonempty_d = 1'b1;
        if (!phase_q) begin
          held_d  = dt_trit;
          phase_d = 1'b1;
        end else begin
          phase_d             = 1'b0;
          push                = pc[3];
          push_res.code       = pc[2:0];
          push_res.code_valid = 1'b1;
        end
      end else begin
        fill_step = fill_inc;
      end

      if (stream_end_i) begin
        // the closing segment_end, if any, carries run_last instead
        flush_d           = 1'b1;
        skip_d            = tfsd_pkg::fill_t'(WIN_LEN) - fill_step;
        left_d            = fill_step;
        fill_d            = '0;
        push_res.run_last = ~(nonempty_d | (fill_step != '0));
      end else begin
        fill_d            = fill_step;
        push_res.run_last = 1'b1;
      end
    end else if (flush_q) begin
      if (left_q == '0) begin
        // close the final segment and return to reset state
        if (!nonempty_q || room) begin
          push                 = nonempty_q;
          push_res.segment_end = 1'b1;
          push_res.run_last    = 1'b1;
          nonempty_d           = 1'b0;
          phase_d              = 1'b0;
          held_d               = tfsd_pkg::TRIT_ZERO;
          flush_d              = 1'b0;
        end
      end else if (skip_q != '0) begin
        win_d  = win_fl;
        skip_d = skip_q - tfsd_pkg::fill_t'(1);
      end else if (!dt_emit || room) begin
        win_d      = win_fl;
        left_d     = left_q - tfsd_pkg::fill_t'(1);
        nonempty_d = 1'b1;
        if (!phase_q) begin
          held_d  = dt_trit;
          phase_d = 1'b1;
        end else begin
          phase_d             = 1'b0;
          push                = pc[3];
          push_res.code       = pc[2:0];
          push_res.code_valid = 1'b1;
        end
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_q <= HIGH_RST;
      low_q  <= LOW_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tfsd_pkg::REG_HIGH_THRESHOLD: high_q <= cfg_wdata_i;
        tfsd_pkg::REG_LOW_THRESHOLD:  low_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      held_q     <= tfsd_pkg::TRIT_ZERO;
      phase_q    <= 1'b0;
      nonempty_q <= 1'b0;
      flush_q    <= 1'b0;
      skip_q     <= '0;
      left_q     <= '0;
      wr_ptr_q   <= 1'b0;
      rd_ptr_q   <= 1'b0;
      cnt_q      <= 2'd0;
    end else begin
      fill_q     <= fill_d;
      held_q     <= held_d;
      phase_q    <= phase_d;
      nonempty_q <= nonempty_d;
      flush_q    <= flush_d;
      skip_q     <= skip_d;
      left_q     <= left_d;
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  // delay line and queue payload, only read where marked valid
  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    if (push) fifo_q[wr_ptr_q] <= push_res;
  end

  assign out_valid_o   = (cnt_q != 2'd0);
  assign code_o        = fifo_q[rd_ptr_q].code;
  assign code_valid_o  = fifo_q[rd_ptr_q].code_valid;
  assign segment_end_o = fifo_q[rd_ptr_q].segment_end;
  assign run_last_o    = fifo_q[rd_ptr_q].run_last;

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import tfsd_pkg::*;

  localparam int SB            = 12;
  localparam int S_MAX         = 2047;
  localparam int S_MIN         = -2048;
  // cycles without any transfer before the run is declared hung
  localparam int IDLE_LIMIT    = 2000;
  // hold-off after the last result, covers a flush walk plus margin
  localparam int SETTLE_CYCLES = 60;

  // dut ports; all inputs driven to known values from time zero
  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 cfg_we_i     = 1'b0;
  logic [0:0]           cfg_index_i  = '0;
  logic [SB-1:0]        cfg_wdata_i  = '0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_stall_o;
  logic signed [SB-1:0] sample_i     = '0;
  logic                 stream_end_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i  = 1'b0;
  logic [2:0]           code_o;
  logic                 code_valid_o;
  logic                 segment_end_o;
  logic                 run_last_o;

  ternary_frame_sync_decoder #(
    .SAMPLE_BITS(SB)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_i     (sample_i),
    .stream_end_i (stream_end_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .code_o       (code_o),
    .code_valid_o (code_valid_o),
    .segment_end_o(segment_end_o),
    .run_last_o   (run_last_o)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // decoder prediction: own copy of thresholds, delay line and pairing state
  // ---------------------------------------------------------------------------
  int      hi_th;
  int      lo_th;
  trit_t   line_q [WIN_LEN];
  int      line_fill;
  trit_t   first_trit;
  bit      have_first;
  bit      seg_has_data;
  result_t step_res [$];
  result_t expected_q [$];

  // run statistics
  int errors        = 0;
  int items_sent    = 0;
  int markers_sent  = 0;
  int results_seen  = 0;
  int segments_seen = 0;
  int settings_used = 0;
  int tail_next     = 0;
  // when set, neither side inserts gaps or stalls
  bit steady        = 1'b0;

  function automatic void reset_decoder_model();
    hi_th        = THRESH_RST_MAG;
    lo_th        = -THRESH_RST_MAG;
    line_fill    = 0;
    first_trit   = TRIT_ZERO;
    have_first   = 1'b0;
    seg_has_data = 1'b0;
    foreach (line_q[i]) line_q[i] = TRIT_ZERO;
  endfunction

  // +1 test wins, so overlapping thresholds slice to +1
  function automatic trit_t slice_trit(int s);
    if (s > hi_th) return TRIT_POS;
    if (s < lo_th) return TRIT_NEG;
    return TRIT_ZERO;
  endfunction

  function automatic void push_result(logic [2:0] c, logic v, logic se);
    result_t r;
    r.code        = c;
    r.code_valid  = v;
    r.segment_end = se;
    r.run_last    = 1'b0;
    step_res.insert(step_res.size(), r);
  endfunction

  // pair data trits in order; (0,0) produces nothing
  function automatic void take_data_trit(trit_t t);
    int pv;
    seg_has_data = 1'b1;
    if (!have_first) begin
      first_trit = t;
      have_first = 1'b1;
      return;
    end
    have_first = 1'b0;
    pv = 3 * (int'(first_trit) + 1) + int'(t) + 1;
    if (pv == 4) return;
    if (pv > 4) pv--;
    push_result(3'(pv), 1'b1, 1'b0);
  endfunction

  // an unpaired trit is dropped when the segment closes
  function automatic void close_segment_model();
    if (seg_has_data) push_result(3'd0, 1'b0, 1'b1);
    seg_has_data = 1'b0;
    have_first   = 1'b0;
    first_trit   = TRIT_ZERO;
  endfunction

  function automatic trit_t preamble_trit(int i);
    return (i % 4 == 0 || i % 4 == 3) ? TRIT_POS : TRIT_NEG;
  endfunction

  // tails: (0,+1), or +1 followed by anything
  function automatic bit sync_in_line();
    for (int i = 0; i < PRE_LEN; i++) begin
      if (line_q[i] != preamble_trit(i)) return 1'b0;
    end
    if (line_q[PRE_LEN] == TRIT_ZERO) return line_q[PRE_LEN+1] == TRIT_POS;
    return line_q[PRE_LEN] == TRIT_POS;
  endfunction

  function automatic void predict_sample(int s, bit last);
    result_t r;
    if (line_fill >= WIN_LEN) line_fill = WIN_LEN - 1;
    line_q[line_fill] = slice_trit(s);
    line_fill++;
    if (line_fill == WIN_LEN) begin
      if (sync_in_line()) begin
        line_fill = 0;
        close_segment_model();
      end else begin
        take_data_trit(line_q[0]);
        for (int i = 0; i < WIN_LEN - 1; i++) line_q[i] = line_q[i+1];
        line_q[WIN_LEN-1] = TRIT_ZERO;
        line_fill = WIN_LEN - 1;
      end
    end
    // stream end: whatever is left in the line is data, never a marker
    if (last) begin
      for (int i = 0; i < line_fill; i++) take_data_trit(line_q[i]);
      close_segment_model();
      foreach (line_q[i]) line_q[i] = TRIT_ZERO;
      line_fill = 0;
    end
    if (step_res.size() > 0) begin
      r = step_res[step_res.size() - 1];
      r.run_last = 1'b1;
      step_res[step_res.size() - 1] = r;
    end
    foreach (step_res[i]) expected_q.insert(expected_q.size(), step_res[i]);
    step_res.delete();
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic int noise_sample();
    return int'($urandom_range(0, 4095)) - 2048;
  endfunction

  function automatic trit_t rand_trit();
    case ($urandom_range(0, 2))
      0:       return TRIT_NEG;
      1:       return TRIT_ZERO;
      default: return TRIT_POS;
    endcase
  endfunction

  // a sample that slices to t under the current thresholds (needs lo <= hi
  // and room on both sides), often right on a slicer boundary
  function automatic int sample_for(trit_t t);
    int lo_b;
    int hi_b;
    int pick;
    if (t == TRIT_POS) begin
      lo_b = hi_th + 1;
      hi_b = S_MAX;
    end else if (t == TRIT_NEG) begin
      lo_b = S_MIN;
      hi_b = lo_th - 1;
    end else begin
      lo_b = lo_th;
      hi_b = hi_th;
    end
    pick = $urandom_range(0, 7);
    if (pick == 0) return lo_b;
    if (pick == 1) return hi_b;
    return lo_b + int'($urandom_range(0, hi_b - lo_b));
  endfunction

  // one input transfer; called at a rising edge, returns at the accepting edge
  task automatic send_sample(int s, bit last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    sample_i     <= s[SB-1:0];
    stream_end_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    predict_sample(s, last);
    items_sent++;
  endtask

  task automatic send_trit(trit_t t, bit last);
    send_sample(sample_for(t), last);
  endtask

  // full 36-trit sync marker; a broken one has a bad preamble trit or tail
  task automatic send_marker(bit broken);
    trit_t mk [WIN_LEN];
    int    flip;
    for (int i = 0; i < PRE_LEN; i++) mk[i] = preamble_trit(i);
    case (tail_next)
      0: begin mk[PRE_LEN] = TRIT_ZERO; mk[PRE_LEN+1] = TRIT_POS;  end
      1: begin mk[PRE_LEN] = TRIT_POS;  mk[PRE_LEN+1] = TRIT_NEG;  end
      2: begin mk[PRE_LEN] = TRIT_POS;  mk[PRE_LEN+1] = TRIT_ZERO; end
      default: begin mk[PRE_LEN] = TRIT_POS; mk[PRE_LEN+1] = TRIT_POS; end
    endcase
    if (broken) begin
      flip = $urandom_range(0, WIN_LEN - 1);
      if (flip < PRE_LEN) begin
        mk[flip] = ($urandom_range(0, 1) == 0) ? TRIT_ZERO :
                   (mk[flip] == TRIT_POS) ? TRIT_NEG : TRIT_POS;
      end else if (flip == PRE_LEN) begin
        mk[PRE_LEN] = TRIT_NEG;
      end else begin
        mk[PRE_LEN]   = TRIT_ZERO;
        mk[PRE_LEN+1] = ($urandom_range(0, 1) == 0) ? TRIT_ZERO : TRIT_NEG;
      end
    end else begin
      tail_next = (tail_next + 1) % 4;
      markers_sent++;
    end
    for (int i = 0; i < WIN_LEN; i++) send_trit(mk[i], 1'b0);
  endtask

  // wait for every expected result, then let the block settle
  task automatic drain();
    in_valid_i   <= 1'b0;
    stream_end_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // writes the high, then the low threshold register; only while idle
  task automatic set_thresholds(int hi, int lo);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_HIGH_THRESHOLD;
    cfg_wdata_i <= hi[SB-1:0];
    @(posedge clk_i);
    cfg_index_i <= REG_LOW_THRESHOLD;
    cfg_wdata_i <= lo[SB-1:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    hi_th = hi;
    lo_th = lo;
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // reset thresholds, slicer boundaries and sample extremes; short stream
  // flushed at stream end with an odd trailing trit
  task automatic test_default_slicer();
    send_sample(205, 1'b0);
    send_sample(206, 1'b0);
    send_sample(-205, 1'b0);
    send_sample(-206, 1'b0);
    send_sample(S_MAX, 1'b0);
    send_sample(S_MIN, 1'b0);
    send_sample(0, 1'b0);
    send_sample(-1, 1'b0);
    send_sample(1, 1'b1);
    drain();
  endtask

  // one lone trit: dropped, but the segment still closes
  task automatic test_single_sample();
    send_sample(-1000, 1'b1);
    drain();
  endtask

  // widest thresholds give only (0,0), so the segment end stands alone;
  // crossed thresholds let the +1 test win
  task automatic test_threshold_extremes();
    set_thresholds(S_MAX, S_MIN);
    send_sample(S_MAX, 1'b0);
    send_sample(S_MIN, 1'b1);
    drain();
    set_thresholds(S_MIN, S_MAX);
    send_sample(S_MIN, 1'b0);
    send_sample(0, 1'b0);
    send_sample(S_MAX, 1'b0);
    send_sample(S_MIN + 1, 1'b1);
    drain();
  endtask

  // mostly well-formed frames: data trits then a sync marker, with broken
  // markers, raw noise and early stream ends mixed in
  task automatic run_frames(int n_items);
    int start;
    int k;
    int n;
    start = items_sent;
    while (items_sent - start < n_items) begin
      k = $urandom_range(0, 99);
      if (k < 65) begin
        n = $urandom_range(0, 12);
        repeat (n) send_trit(rand_trit(), 1'b0);
        send_marker(1'b0);
      end else if (k < 78) begin
        send_marker(1'b1);
      end else if (k < 90) begin
        n = $urandom_range(1, 8);
        repeat (n) send_sample(noise_sample(), 1'b0);
      end else begin
        n = $urandom_range(0, 20);
        repeat (n) send_trit(rand_trit(), 1'b0);
        send_trit(rand_trit(), 1'b1);
      end
      if ($urandom_range(0, 7) == 0) steady = ~steady;
    end
    send_trit(rand_trit(), 1'b1);
  endtask

  task automatic test_framed_stream();
    set_thresholds(THRESH_RST_MAG, -THRESH_RST_MAG);
    run_frames(50);
    drain();
    // zero only for an exact zero sample
    set_thresholds(0, 0);
    run_frames(50);
    drain();
    // +1 and -1 only at the sample extremes
    set_thresholds(S_MAX - 1, S_MIN + 1);
    run_frames(50);
    drain();
    set_thresholds($urandom_range(1, 1500), -int'($urandom_range(0, 1500)));
    run_frames(50);
    drain();
    steady = 1'b0;
  endtask

  // crossed thresholds with raw samples across the whole range
  task automatic test_overlap_noise();
    set_thresholds(-int'($urandom_range(1, 800)), $urandom_range(1, 800));
    repeat (29) send_sample(noise_sample(), 1'b0);
    send_sample(noise_sample(), 1'b1);
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stall, checking, watchdog
  // ---------------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk_i) begin
    if (stall_left == 0 && !steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    out_stall_i <= (stall_left > 0);
    if (stall_left > 0) stall_left--;
  end

  function automatic void note_mismatch(string field, logic [2:0] want, logic [2:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
  endfunction

  // each result transfer against the oldest expectation
  always @(posedge clk_i) begin : check_result
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (segment_end_o === 1'b1) segments_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual code %0h valid %0b end %0b last %0b",
                 $time, code_o, code_valid_o, segment_end_o, run_last_o);
      end else begin
        want = expected_q.pop_front();
        if (code_o !== want.code) note_mismatch("code", want.code, code_o);
        if (code_valid_o !== want.code_valid)
          note_mismatch("code_valid", 3'(want.code_valid), 3'(code_valid_o));
        if (segment_end_o !== want.segment_end)
          note_mismatch("segment_end", 3'(want.segment_end), 3'(segment_end_o));
        if (run_last_o !== want.run_last)
          note_mismatch("run_last", 3'(want.run_last), 3'(run_last_o));
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, expected_q.size());
      $display("[ternary_frame_sync_decoder] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    reset_decoder_model();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_slicer();
    test_single_sample();
    test_threshold_extremes();
    test_framed_stream();
    test_overlap_noise();
    drain();
    $display("run covered %0d samples, %0d sync markers, %0d threshold settings",
             items_sent, markers_sent, settings_used);
    $display("checked %0d results including %0d segment closes, %0d mismatches",
             results_seen, segments_seen, errors);
    if (errors == 0) begin
      $display("[ternary_frame_sync_decoder] OK");
    end else begin
      $display("[ternary_frame_sync_decoder] ERROR");
    end
    $finish;
  end

endmodule
